@@ rtl/obr_pkg.sv @@
// Shared widths, constants and types of the OHLC bar resampler.
`timescale 1ns / 1ps

package obr_pkg;

  localparam int unsigned TIME_W      = 32;
  localparam int unsigned END_W       = TIME_W + 1;
  localparam int unsigned OUT_PRICE_W = 48;
  localparam int unsigned MAX_PRICE_W = 64;
  localparam int unsigned VOL_IN_W    = 32;
  localparam int unsigned VOL_W       = 48;
  localparam int unsigned PERIOD_W    = 31;
  localparam int unsigned FIFO_DEPTH  = 4;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(60);

  typedef struct packed {
    logic [TIME_W-1:0]      out_time;
    logic [OUT_PRICE_W-1:0] out_open;
    logic [OUT_PRICE_W-1:0] out_high;
    logic [OUT_PRICE_W-1:0] out_low;
    logic [OUT_PRICE_W-1:0] out_close;
    logic [VOL_W-1:0]       out_volume;
    logic                   out_last;
  } obr_result_t;

  // Up to two merged bars leave the merge stage per input transaction.
  typedef struct packed {
    logic [1:0]  count;
    obr_result_t first;
    obr_result_t second;
  } obr_push_t;

endpackage

@@ rtl/obr_if.sv @@
// Valid/ready channel interfaces for input bars and merged result bars.
`timescale 1ns / 1ps

interface obr_in_if #(
  parameter int unsigned PRICE_BITS = 48
);
  import obr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [TIME_W-1:0]     bar_time;
  logic [PRICE_BITS-1:0] bar_open;
  logic [PRICE_BITS-1:0] bar_high;
  logic [PRICE_BITS-1:0] bar_low;
  logic [PRICE_BITS-1:0] bar_close;
  logic [VOL_IN_W-1:0]   bar_volume;
  logic                  final_bar;

  modport source (
    output valid, bar_time, bar_open, bar_high, bar_low, bar_close, bar_volume, final_bar,
    input  ready
  );

  modport sink (
    input  valid, bar_time, bar_open, bar_high, bar_low, bar_close, bar_volume, final_bar,
    output ready
  );
endinterface

interface obr_out_if;
  import obr_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TIME_W-1:0]      out_time;
  logic [OUT_PRICE_W-1:0] out_open;
  logic [OUT_PRICE_W-1:0] out_high;
  logic [OUT_PRICE_W-1:0] out_low;
  logic [OUT_PRICE_W-1:0] out_close;
  logic [VOL_W-1:0]       out_volume;
  logic                   out_last;

  modport source (
    output valid, out_time, out_open, out_high, out_low, out_close, out_volume, out_last,
    input  ready
  );

  modport sink (
    input  valid, out_time, out_open, out_high, out_low, out_close, out_volume, out_last,
    output ready
  );
endinterface

@@ rtl/obr_merge.sv @@
// Input register, period state and single-pass merge logic of the resampler.
`timescale 1ns / 1ps

module obr_merge #(
  parameter int unsigned PRICE_BITS = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  obr_in_if.sink                        bar_i,
  input  logic [obr_pkg::PERIOD_W-1:0]  period_i,
  input  logic                          room_i,
  output obr_pkg::obr_push_t            push_o
);
  import obr_pkg::*;

  // Input register.
  logic                  in_valid_q;
  logic [TIME_W-1:0]     t_q;
  logic [PRICE_BITS-1:0] o_q, h_q, l_q, c_q;
  logic [VOL_IN_W-1:0]   v_q;
  logic                  fin_q;

  // Period state.
  logic                  have_q, have_d;
  logic [TIME_W-1:0]     start_q, start_d;
  logic [END_W-1:0]      end_q, end_d;
  logic [PRICE_BITS-1:0] acc_open_q, acc_open_d;
  logic [PRICE_BITS-1:0] acc_high_q, acc_high_d;
  logic [PRICE_BITS-1:0] acc_low_q, acc_low_d;
  logic [PRICE_BITS-1:0] acc_close_q, acc_close_d;
  logic [VOL_W-1:0]      acc_vol_q, acc_vol_d;

  logic                  fire;
  logic                  in_take;
  logic [VOL_W:0]        vol_sum;
  logic [VOL_W-1:0]      vol_sat;
  obr_result_t           bar_res, old_res, new_res;
  obr_push_t             push_d;

  function automatic logic [OUT_PRICE_W-1:0] to_out(input logic [PRICE_BITS-1:0] p);
    logic [MAX_PRICE_W-1:0] w;
    w = MAX_PRICE_W'(p);
    return w[OUT_PRICE_W-1:0];
  endfunction

  assign fire        = in_valid_q && room_i;
  assign bar_i.ready = !in_valid_q || fire;
  assign in_take     = bar_i.valid && bar_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      t_q   <= bar_i.bar_time;
      o_q   <= bar_i.bar_open;
      h_q   <= bar_i.bar_high;
      l_q   <= bar_i.bar_low;
      c_q   <= bar_i.bar_close;
      v_q   <= bar_i.bar_volume;
      fin_q <= bar_i.final_bar;
    end
  end

  assign vol_sum = {1'b0, acc_vol_q} + (VOL_W + 1)'(v_q);
  assign vol_sat = vol_sum[VOL_W] ? {VOL_W{1'b1}} : vol_sum[VOL_W-1:0];

  always_comb begin
    bar_res.out_time   = t_q;
    bar_res.out_open   = to_out(o_q);
    bar_res.out_high   = to_out(h_q);
    bar_res.out_low    = to_out(l_q);
    bar_res.out_close  = to_out(c_q);
    bar_res.out_volume = VOL_W'(v_q);
    bar_res.out_last   = fin_q;

    old_res.out_time   = start_q;
    old_res.out_open   = to_out(acc_open_q);
    old_res.out_high   = to_out(acc_high_q);
    old_res.out_low    = to_out(acc_low_q);
    old_res.out_close  = to_out(acc_close_q);
    old_res.out_volume = acc_vol_q;
    old_res.out_last   = 1'b0;

    have_d      = have_q;
    start_d     = start_q;
    end_d       = end_q;
    acc_open_d  = acc_open_q;
    acc_high_d  = acc_high_q;
    acc_low_d   = acc_low_q;
    acc_close_d = acc_close_q;
    acc_vol_d   = acc_vol_q;

    push_d.count  = 2'd0;
    push_d.first  = old_res;
    push_d.second = bar_res;
    new_res       = old_res;

    if (fire) begin
      if (period_i == '0) begin
        have_d = 1'b0;
        if (have_q) begin
          push_d.count = 2'd2;
        end else begin
          push_d.first = bar_res;
          push_d.count = 2'd1;
        end
      end else begin
        if (!have_q) begin
          have_d      = 1'b1;
          start_d     = t_q;
          end_d       = END_W'(t_q) + END_W'(period_i);
          acc_open_d  = o_q;
          acc_high_d  = h_q;
          acc_low_d   = l_q;
          acc_close_d = c_q;
          acc_vol_d   = VOL_W'(v_q);
        end else if ({1'b0, t_q} < end_q) begin
          if (h_q > acc_high_q) begin
            acc_high_d = h_q;
          end
          if (l_q < acc_low_q) begin
            acc_low_d = l_q;
          end
          acc_close_d = c_q;
          acc_vol_d   = vol_sat;
        end else begin
          // The period steps forward from the old end, not from this bar's time.
          push_d.count = 2'd1;
          start_d      = end_q[TIME_W-1:0];
          end_d        = END_W'(end_q[TIME_W-1:0]) + END_W'(period_i);
          acc_open_d   = o_q;
          acc_high_d   = h_q;
          acc_low_d    = l_q;
          acc_close_d  = c_q;
          acc_vol_d    = VOL_W'(v_q);
        end

        if (fin_q) begin
          have_d             = 1'b0;
          new_res.out_time   = start_d;
          new_res.out_open   = to_out(acc_open_d);
          new_res.out_high   = to_out(acc_high_d);
          new_res.out_low    = to_out(acc_low_d);
          new_res.out_close  = to_out(acc_close_d);
          new_res.out_volume = acc_vol_d;
          new_res.out_last   = 1'b1;
          if (push_d.count == 2'd1) begin
            push_d.second = new_res;
            push_d.count  = 2'd2;
          end else begin
            push_d.first = new_res;
            push_d.count = 2'd1;
          end
        end
      end
    end
  end

  assign push_o = push_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    end_q       <= end_d;
    acc_open_q  <= acc_open_d;
    acc_high_q  <= acc_high_d;
    acc_low_q   <= acc_low_d;
    acc_close_q <= acc_close_d;
    acc_vol_q   <= acc_vol_d;
  end

  a_final_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && fin_q |=> !have_q)
    else $error("final bar left a period open");

  a_zero_period_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (period_i == '0) |-> push_d.count != 2'd0)
    else $error("pass-through bar produced no result");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_d.count == 2'd2 |-> !push_d.first.out_last)
    else $error("first of two results marked last");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |-> push_d.count == 2'd0)
    else $error("result pushed without a transaction");

endmodule

@@ rtl/obr_result_fifo.sv @@
// Result queue that takes up to two merged bars per cycle and sends one.
`timescale 1ns / 1ps

module obr_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  obr_pkg::obr_push_t push_i,
  output logic               room_o,
  obr_out_if.source          res_o
);
  import obr_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  obr_result_t        mem [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               pop;
  obr_result_t        head;

  assign head             = mem[rd_ptr_q];
  assign res_o.valid      = count_q != '0;
  assign res_o.out_time   = head.out_time;
  assign res_o.out_open   = head.out_open;
  assign res_o.out_high   = head.out_high;
  assign res_o.out_low    = head.out_low;
  assign res_o.out_close  = head.out_close;
  assign res_o.out_volume = head.out_volume;
  assign res_o.out_last   = head.out_last;

  assign pop = res_o.valid && res_o.ready;
  // Room for a full pair is judged on the registered count alone.
  assign room_o = count_q <= CNT_W'(FIFO_DEPTH - 2);

  assign wr_ptr_d = wr_ptr_q + PTR_W'(push_i.count);
  assign rd_ptr_d = rd_ptr_q + PTR_W'(pop);
  assign count_d  = count_q + CNT_W'(push_i.count) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem[wr_ptr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> room_o)
    else $error("push into a queue without room");

  a_count_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd0) && !pop |=> $stable(count_q))
    else $error("queue count moved without a push or pop");

endmodule

@@ rtl/ohlc_bar_resampler_unit.sv @@
// An accepted bar waits in the input register until the result queue has room. Throughput:
// one input bar per cycle; the output sends one merged bar per cycle while ready is high, so
// a bar that yields two results holds the single output port for both, with a four-entry
// result queue absorbing the difference. The input stalls while three or more are queued.
// Reset: bar length returns to 60 seconds, no period is open and the result queue is empty.
`timescale 1ns / 1ps

module ohlc_bar_resampler_unit #(
  parameter int unsigned PRICE_BITS = 48
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [obr_pkg::PERIOD_W-1:0] cfg_data_i,
  obr_in_if.sink                       bar_i,
  obr_out_if.source                    res_o
);
  import obr_pkg::*;

  logic [PERIOD_W-1:0] period_q;
  logic                room;
  obr_push_t           push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  obr_merge #(
    .PRICE_BITS (PRICE_BITS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bar_i    (bar_i),
    .period_i (period_q),
    .room_i   (room),
    .push_o   (push)
  );

  obr_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .res_o  (res_o)
  );

endmodule
